@@ rtl/core/wfpd_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// wfpd_pkg
// Shared types, constants and helpers of the wall-following PD drive block.
// ============================================================================
package wfpd_pkg;

    // Echo time width of the sensor inputs.
    localparam int ECHO_WIDTH = 16;
    localparam int TARGET_W   = 16;

    // PD datapath widths.
    localparam int ERR_W = ((ECHO_WIDTH > TARGET_W) ? ECHO_WIDTH : TARGET_W) + 1;
    localparam int DIF_W = ERR_W + 1;
    localparam int GAIN_W = 10;
    localparam int PE_W  = ERR_W + GAIN_W + 1;
    localparam int PD_W  = DIF_W + GAIN_W + 1;
    localparam int P_W   = ERR_W + 5;
    localparam int SP_W  = P_W + 1;

    // Command queue between classifier and command sequencer.
    localparam int QUEUE_DEPTH = 4;

    // Thresholds on the echo times.
    localparam int FRONT_NEAR  = 500;
    localparam int SIDE_SEEN   = 1000;
    localparam int SIDE_DONE   = 500;
    localparam int FRONT_CRASH = 340;

    // Fixed speeds and hold times.
    localparam int FWD_TRIM   = 65;
    localparam int SPD_HIGH   = 255;
    localparam int SPD_MID    = 190;
    localparam int SPD_LOW    = 70;
    localparam int HOLD_LONG  = 150;
    localparam int HOLD_SHORT = 125;

    // Register reset values.
    localparam logic        RST_FOLLOW_SIDE     = 1'b0;
    localparam logic [15:0] RST_DISTANCE_TARGET = 16'd25;
    localparam logic [7:0]  RST_BASE_SPEED      = 8'd235;
    localparam logic [7:0]  RST_SPEED_CEILING   = 8'd255;
    localparam logic [7:0]  RST_SPEED_FLOOR     = 8'd205;
    localparam logic [9:0]  RST_GAIN_PROP       = 10'd179;
    localparam logic [9:0]  RST_GAIN_DERIV      = 10'd46;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FOLLOW_SIDE     = 3'd0,
        CFG_DISTANCE_TARGET = 3'd1,
        CFG_BASE_SPEED      = 3'd2,
        CFG_SPEED_CEILING   = 3'd3,
        CFG_SPEED_FLOOR     = 3'd4,
        CFG_GAIN_PROP       = 3'd5,
        CFG_GAIN_DERIV      = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DRV_FWD   = 2'd0,
        DRV_BACK  = 2'd1,
        DRV_LEFT  = 2'd2,
        DRV_RIGHT = 2'd3
    } drive_t;

    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_BACK  = 2'd1,
        PH_TURN  = 2'd2
    } phase_t;

    typedef struct packed {
        logic              follow_side;
        logic [15:0]       distance_target;
        logic [7:0]        base_speed;
        logic [7:0]        speed_ceiling;
        logic [7:0]        speed_floor;
        logic [GAIN_W-1:0] gain_prop;
        logic [GAIN_W-1:0] gain_deriv;
    } cfg_t;

    typedef struct packed {
        logic [ECHO_WIDTH-1:0] front_echo;
        logic [ECHO_WIDTH-1:0] side_echo;
    } in_t;

    typedef struct packed {
        drive_t     drive;
        logic [7:0] speed_a;
        logic [7:0] speed_b;
        logic [7:0] hold_ms;
        logic       last;
    } out_t;

    typedef struct packed {
        drive_t     drive;
        logic [7:0] speed_a;
        logic [7:0] speed_b;
    } cmd_t;

    // One queued sample: its main command (if any) and the back-up pair flag.
    typedef struct packed {
        logic has_main;
        logic crash;
        logic right_mode;
        cmd_t main;
    } rec_t;

    function automatic logic [7:0] sat8(input logic signed [SP_W-1:0] v);
        logic [7:0] res;
        if (v < 0) begin
            res = 8'd0;
        end else if (v > $signed(SP_W'(255))) begin
            res = 8'd255;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/core/wfpd_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// wfpd_front
// Accepts echo samples, tracks the turn state and computes the PD command.
// ============================================================================
module wfpd_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  wfpd_pkg::cfg_t  cfg,
    input  logic            s_valid,
    output logic            s_ready,
    input  wfpd_pkg::in_t   s_data,
    output logic            q_push,
    output wfpd_pkg::rec_t  q_rec,
    input  logic            q_full
);

    localparam int EW    = wfpd_pkg::ECHO_WIDTH;
    localparam int ERR_W = wfpd_pkg::ERR_W;
    localparam int DIF_W = wfpd_pkg::DIF_W;
    localparam int PE_W  = wfpd_pkg::PE_W;
    localparam int PD_W  = wfpd_pkg::PD_W;
    localparam int P_W   = wfpd_pkg::P_W;
    localparam int SP_W  = wfpd_pkg::SP_W;

    typedef struct packed {
        logic           is_pd;
        logic           has_main;
        logic           crash;
        logic           right_mode;
        wfpd_pkg::cmd_t main;
    } tag_t;

    // Turn state and PD memory.
    logic                    turn_left_reg, turn_left_next;
    logic                    turn_right_reg, turn_right_next;
    logic signed [ERR_W-1:0] prev_err_reg, prev_err_next;

    // Pipeline stages.
    logic                    s1_valid_reg, s2_valid_reg, s3_valid_reg;
    tag_t                    s1_tag_reg, s2_tag_reg, s3_tag_reg;
    tag_t                    tag_next;
    logic signed [ERR_W-1:0] s1_err_reg;
    logic signed [DIF_W-1:0] s1_dif_reg;
    logic signed [PE_W-1:0]  s2_pe_reg;
    logic signed [PD_W-1:0]  s2_pd_reg;
    logic signed [P_W-1:0]   s3_p_reg;

    logic                    adv;
    logic                    accept;
    logic [EW-1:0]           front, side;
    logic signed [ERR_W-1:0] err;
    logic signed [DIF_W-1:0] dif;
    logic signed [PE_W-1:0]  pe_adj;
    logic signed [PD_W-1:0]  pd_adj;
    logic signed [P_W-1:0]   p_sum;
    logic signed [SP_W-1:0]  r_spd, l_spd, ceil_s, floor_s;
    wfpd_pkg::cmd_t          pd_cmd;

    // A stage-3 sample that needs no command does not wait for queue space.
    assign adv     = !(s3_valid_reg && (s3_tag_reg.has_main || s3_tag_reg.crash) && q_full);
    assign s_ready = adv;
    assign accept  = s_valid && s_ready;
    assign front   = s_data.front_echo;
    assign side    = s_data.side_echo;

    assign err = $signed(ERR_W'(side)) - $signed(ERR_W'(cfg.distance_target));
    assign dif = DIF_W'(err) - DIF_W'(prev_err_reg);

    // Classify the sample against the turn state it finds.
    always_comb begin
        turn_left_next      = turn_left_reg;
        turn_right_next     = turn_right_reg;
        prev_err_next       = prev_err_reg;
        tag_next.is_pd      = 1'b0;
        tag_next.has_main   = 1'b0;
        tag_next.crash      = (front < EW'(wfpd_pkg::FRONT_CRASH));
        tag_next.right_mode = cfg.follow_side;
        tag_next.main       = '{wfpd_pkg::DRV_FWD, 8'd0, 8'd0};
        if (!turn_left_reg && !turn_right_reg) begin
            if (side < EW'(wfpd_pkg::SIDE_SEEN)) begin
                if (front < EW'(wfpd_pkg::FRONT_NEAR)) begin
                    turn_right_next = 1'b1;
                end else begin
                    tag_next.is_pd    = 1'b1;
                    tag_next.has_main = 1'b1;
                    prev_err_next     = err;
                end
            end else if (cfg.follow_side) begin
                turn_right_next = 1'b1;
            end else begin
                turn_left_next = 1'b1;
            end
        end else if (turn_left_reg) begin
            tag_next.has_main = 1'b1;
            if (cfg.follow_side) begin
                tag_next.main = '{wfpd_pkg::DRV_LEFT, 8'd0, 8'(wfpd_pkg::SPD_MID)};
            end else begin
                tag_next.main = '{wfpd_pkg::DRV_LEFT, 8'(wfpd_pkg::SPD_LOW),
                                  8'(wfpd_pkg::SPD_MID)};
            end
            if (side <= EW'(wfpd_pkg::SIDE_DONE)) begin
                turn_left_next = 1'b0;
            end
        end else begin
            tag_next.has_main = 1'b1;
            if (cfg.follow_side) begin
                tag_next.main = '{wfpd_pkg::DRV_RIGHT, 8'(wfpd_pkg::SPD_HIGH),
                                  8'(wfpd_pkg::SPD_LOW)};
            end else begin
                tag_next.main = '{wfpd_pkg::DRV_RIGHT, 8'(wfpd_pkg::SPD_HIGH), 8'd0};
            end
            if (side <= EW'(wfpd_pkg::SIDE_DONE)) begin
                turn_right_next = 1'b0;
            end
        end
    end

    // Division by 256 truncating toward zero: bias negative values first.
    always_comb begin
        pe_adj = s2_pe_reg + $signed(PE_W'(s2_pe_reg[PE_W-1] ? 255 : 0));
        pd_adj = s2_pd_reg + $signed(PD_W'(s2_pd_reg[PD_W-1] ? 255 : 0));
        p_sum  = P_W'($signed(pe_adj[PE_W-1:8])) + P_W'($signed(pd_adj[PD_W-1:8]));
    end

    // Wheel speeds, ceiling clamp and the drive decision around the floor.
    always_comb begin
        ceil_s  = SP_W'($signed({1'b0, cfg.speed_ceiling}));
        floor_s = SP_W'($signed({1'b0, cfg.speed_floor}));
        r_spd   = SP_W'($signed({1'b0, cfg.base_speed})) + SP_W'(s3_p_reg);
        l_spd   = SP_W'($signed({1'b0, cfg.base_speed})) - SP_W'(s3_p_reg);
        if (r_spd > ceil_s) begin
            r_spd = ceil_s;
        end
        if (l_spd > ceil_s) begin
            l_spd = ceil_s;
        end
        if (r_spd <= floor_s && l_spd > floor_s) begin
            pd_cmd = '{wfpd_pkg::DRV_RIGHT, wfpd_pkg::sat8((floor_s <<< 1) - r_spd),
                       wfpd_pkg::sat8(l_spd)};
        end else if (l_spd <= floor_s && r_spd > floor_s) begin
            pd_cmd = '{wfpd_pkg::DRV_LEFT, wfpd_pkg::sat8(r_spd),
                       wfpd_pkg::sat8((floor_s <<< 1) - l_spd)};
        end else begin
            pd_cmd = '{wfpd_pkg::DRV_FWD,
                       wfpd_pkg::sat8(r_spd - SP_W'(wfpd_pkg::FWD_TRIM)),
                       wfpd_pkg::sat8(l_spd)};
        end
    end

    always_comb begin
        q_rec.has_main   = s3_tag_reg.has_main;
        q_rec.crash      = s3_tag_reg.crash;
        q_rec.right_mode = s3_tag_reg.right_mode;
        q_rec.main       = s3_tag_reg.is_pd ? pd_cmd : s3_tag_reg.main;
    end

    assign q_push = adv && s3_valid_reg && (s3_tag_reg.has_main || s3_tag_reg.crash);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            turn_left_reg  <= 1'b0;
            turn_right_reg <= 1'b0;
            prev_err_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                turn_left_reg  <= turn_left_next;
                turn_right_reg <= turn_right_next;
                prev_err_reg   <= prev_err_next;
            end
            if (adv) begin
                s1_valid_reg <= s_valid;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_tag_reg <= tag_next;
            s1_err_reg <= err;
            s1_dif_reg <= dif;
            s2_tag_reg <= s1_tag_reg;
            s2_pe_reg  <= PE_W'(s1_err_reg) * PE_W'($signed({1'b0, cfg.gain_prop}));
            s2_pd_reg  <= PD_W'(s1_dif_reg) * PD_W'($signed({1'b0, cfg.gain_deriv}));
            s3_tag_reg <= s2_tag_reg;
            s3_p_reg   <= p_sum;
        end
    end

endmodule

@@ rtl/core/wfpd_queue.sv @@
`timescale 1ns / 1ps
// ============================================================================
// wfpd_queue
// Small FIFO of per-sample command records between classifier and sequencer.
// ============================================================================
module wfpd_queue #(
    parameter int DEPTH = wfpd_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  wfpd_pkg::rec_t push_rec,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output wfpd_pkg::rec_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wfpd_pkg::rec_t     mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/wfpd_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// wfpd_back
// Expands queued records into drive commands, one per cycle while m_ready
// does not stall the output, into the output register.
// ============================================================================
module wfpd_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  wfpd_pkg::rec_t q_rec,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output wfpd_pkg::out_t m_data
);

    wfpd_pkg::phase_t phase_reg, phase_next;
    logic             m_valid_reg;
    wfpd_pkg::out_t   m_data_reg;
    wfpd_pkg::out_t   cur;
    logic             rec_done;
    logic             load;

    assign load    = q_valid && (!m_valid_reg || m_ready);
    assign q_pop   = load && rec_done;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Command produced by the current phase of the head record.
    always_comb begin
        cur      = '{wfpd_pkg::DRV_BACK, 8'(wfpd_pkg::SPD_HIGH), 8'(wfpd_pkg::SPD_MID),
                     8'(wfpd_pkg::HOLD_LONG), 1'b0};
        rec_done = 1'b0;
        case (phase_reg)
            wfpd_pkg::PH_FIRST: begin
                if (q_rec.has_main) begin
                    cur      = '{q_rec.main.drive, q_rec.main.speed_a, q_rec.main.speed_b,
                                 8'd0, !q_rec.crash};
                    rec_done = !q_rec.crash;
                end
            end
            wfpd_pkg::PH_BACK: begin
            end
            wfpd_pkg::PH_TURN: begin
                rec_done = 1'b1;
                if (q_rec.right_mode) begin
                    cur = '{wfpd_pkg::DRV_LEFT, 8'd0, 8'(wfpd_pkg::SPD_MID),
                            8'(wfpd_pkg::HOLD_SHORT), 1'b1};
                end else begin
                    cur = '{wfpd_pkg::DRV_RIGHT, 8'(wfpd_pkg::SPD_HIGH), 8'd0,
                            8'(wfpd_pkg::HOLD_LONG), 1'b1};
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        if (load) begin
            case (phase_reg)
                wfpd_pkg::PH_FIRST: begin
                    if (!q_rec.has_main) begin
                        phase_next = wfpd_pkg::PH_TURN;
                    end else if (q_rec.crash) begin
                        phase_next = wfpd_pkg::PH_BACK;
                    end
                end
                wfpd_pkg::PH_BACK: phase_next = wfpd_pkg::PH_TURN;
                wfpd_pkg::PH_TURN: phase_next = wfpd_pkg::PH_FIRST;
                default:           phase_next = wfpd_pkg::PH_FIRST;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= wfpd_pkg::PH_FIRST;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= cur;
        end
    end

endmodule

@@ rtl/core/wall_follow_pd_drive.sv @@
`timescale 1ns / 1ps
// ============================================================================
// wall_follow_pd_drive
// Wall-following PD drive controller: echo samples in, drive commands out.
// ============================================================================
// A new echo sample can be accepted every cycle unless the queue is full and
// the stage-3 sample must be pushed. Each sample passes a three-stage
// classifier (turn state and PD error, the gain multiplies, then truncation,
// speed clamp and drive choice) and, if it yields a command, lands as one
// record in a QUEUE_DEPTH-entry queue. The command sequencer sends one drive
// command per cycle while m_ready allows, finishing each record before it
// takes the next; a sample yields 0 to 3 commands.
// Configuration writes take effect at once and belong in idle periods only.
module wall_follow_pd_drive #(
    parameter int QUEUE_DEPTH = wfpd_pkg::QUEUE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [wfpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [wfpd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  wfpd_pkg::in_t                       s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output wfpd_pkg::out_t                      m_data
);

    wfpd_pkg::cfg_t cfg_reg;
    logic           q_push, q_full, q_pop, q_valid;
    wfpd_pkg::rec_t q_push_rec, q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.follow_side     <= wfpd_pkg::RST_FOLLOW_SIDE;
            cfg_reg.distance_target <= wfpd_pkg::RST_DISTANCE_TARGET;
            cfg_reg.base_speed      <= wfpd_pkg::RST_BASE_SPEED;
            cfg_reg.speed_ceiling   <= wfpd_pkg::RST_SPEED_CEILING;
            cfg_reg.speed_floor     <= wfpd_pkg::RST_SPEED_FLOOR;
            cfg_reg.gain_prop       <= wfpd_pkg::RST_GAIN_PROP;
            cfg_reg.gain_deriv      <= wfpd_pkg::RST_GAIN_DERIV;
        end else if (cfg_we) begin
            case (cfg_index)
                wfpd_pkg::CFG_FOLLOW_SIDE:     cfg_reg.follow_side     <= cfg_wdata[0];
                wfpd_pkg::CFG_DISTANCE_TARGET: cfg_reg.distance_target <= cfg_wdata[15:0];
                wfpd_pkg::CFG_BASE_SPEED:      cfg_reg.base_speed      <= cfg_wdata[7:0];
                wfpd_pkg::CFG_SPEED_CEILING:   cfg_reg.speed_ceiling   <= cfg_wdata[7:0];
                wfpd_pkg::CFG_SPEED_FLOOR:     cfg_reg.speed_floor     <= cfg_wdata[7:0];
                wfpd_pkg::CFG_GAIN_PROP: begin
                    cfg_reg.gain_prop <= cfg_wdata[wfpd_pkg::GAIN_W-1:0];
                end
                wfpd_pkg::CFG_GAIN_DERIV: begin
                    cfg_reg.gain_deriv <= cfg_wdata[wfpd_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    wfpd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_push  (q_push),
        .q_rec   (q_push_rec),
        .q_full  (q_full)
    );

    wfpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_rec (q_push_rec),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    wfpd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_rec   (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ sim/wall_follow_pd_drive_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// wall_follow_pd_drive_tb
// Self-checking bench for the wall-following PD drive block. A directed
// table covers the turn cases, the back-up commands and the echo thresholds.
// Randomized echo samples follow under several register settings. Every
// drive command is checked against the table or a cycle-free model.
// ============================================================================
module wall_follow_pd_drive_tb;

    // Thresholds and fixed command values of the controller.
    localparam int FRONT_TURN_US   = 500;
    localparam int SIDE_OPEN_US    = 1000;
    localparam int SIDE_CLEAR_US   = 500;
    localparam int FRONT_BACKUP_US = 340;
    localparam int FWD_OFFSET      = 65;
    localparam int SPEED_MAX       = 255;
    localparam int SPEED_MID       = 190;
    localparam int SPEED_SLOW      = 70;
    localparam int HOLD_BACKUP_MS  = 150;
    localparam int HOLD_PIVOT_MS   = 125;

    localparam logic [2:0] REG_UNUSED = 3'd7;

    localparam int DIR_ROWS        = 27;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 57;
    localparam int DRAIN_CYCLES    = 24;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int PRINT_CAP       = 200;

    typedef struct packed {
        logic                  is_reg;
        logic [2:0]            reg_idx;
        logic [15:0]           reg_val;
        wfpd_pkg::in_t         item;
        logic [1:0]            n_typed;
        wfpd_pkg::out_t [2:0]  typed;
    } dir_row_t;

    logic           aclk      = 1'b0;
    logic           aresetn   = 1'b0;
    logic           cfg_we    = 1'b0;
    logic [2:0]     cfg_index = '0;
    logic [15:0]    cfg_wdata = '0;
    logic           s_valid   = 1'b0;
    logic           s_ready;
    wfpd_pkg::in_t  s_data    = '0;
    logic           m_valid;
    logic           m_ready   = 1'b0;
    wfpd_pkg::out_t m_data;

    // Model state and register shadow.
    logic           turn_left;
    logic           turn_right;
    int             prev_err;
    wfpd_pkg::cfg_t reg_shadow;

    wfpd_pkg::out_t pending_cmds [$];
    dir_row_t       dir_tab [DIR_ROWS];
    int             mismatch_count = 0;
    int             cycle_count    = 0;
    bit             quiet_all      = 1'b0;
    int             tx_calm        = 0;
    int             rx_calm        = 0;
    int             rx_stall       = 0;

    wall_follow_pd_drive u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #2 aclk = ~aclk;

    function automatic logic [7:0] clip_u8(int v);
        logic [7:0] res;
        if (v < 0) begin
            res = 8'd0;
        end else if (v > 255) begin
            res = 8'd255;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

    function automatic wfpd_pkg::out_t mk_cmd(wfpd_pkg::drive_t dv, int a, int b, int h,
                                              bit lst);
        wfpd_pkg::out_t c;
        c.drive   = dv;
        c.speed_a = clip_u8(a);
        c.speed_b = clip_u8(b);
        c.hold_ms = h[7:0];
        c.last    = lst;
        return c;
    endfunction

    function automatic dir_row_t row_item(int f, int s, int n, wfpd_pkg::out_t t0,
                                          wfpd_pkg::out_t t1, wfpd_pkg::out_t t2);
        dir_row_t r;
        r = '0;
        r.item.front_echo = f[15:0];
        r.item.side_echo  = s[15:0];
        r.n_typed         = n[1:0];
        r.typed[0]        = t0;
        r.typed[1]        = t1;
        r.typed[2]        = t2;
        return r;
    endfunction

    function automatic dir_row_t row_reg(logic [2:0] idx, logic [15:0] val);
        dir_row_t r;
        r = '0;
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // Computes the drive commands caused by one echo sample and advances the
    // turn flags and the stored PD error. With keep set, the commands are
    // queued as expected results.
    function automatic void predict_drive_cmds(wfpd_pkg::in_t it, bit keep);
        wfpd_pkg::out_t cmds [3];
        int   k, i, fr, sd, tgt, e, d, p, r, l, fl, ceil_v, base, gp, gd;
        bit   right_mode, done;
        k          = 0;
        fr         = int'(it.front_echo);
        sd         = int'(it.side_echo);
        tgt        = int'(reg_shadow.distance_target);
        base       = int'(reg_shadow.base_speed);
        ceil_v     = int'(reg_shadow.speed_ceiling);
        fl         = int'(reg_shadow.speed_floor);
        gp         = int'(reg_shadow.gain_prop);
        gd         = int'(reg_shadow.gain_deriv);
        right_mode = reg_shadow.follow_side;
        done       = (sd <= SIDE_CLEAR_US);

        if (!turn_left && !turn_right) begin
            if (sd < SIDE_OPEN_US) begin
                if (fr < FRONT_TURN_US) begin
                    turn_right = 1'b1;
                end else begin
                    e = sd - tgt;
                    d = e - prev_err;
                    // Each product truncates toward zero on its own.
                    p = (e * gp) / 256 + (d * gd) / 256;
                    prev_err = e;
                    r = base + p;
                    l = base - p;
                    if (r > ceil_v) r = ceil_v;
                    if (l > ceil_v) l = ceil_v;
                    if (r <= fl && l > fl) begin
                        cmds[k] = mk_cmd(wfpd_pkg::DRV_RIGHT, 2 * fl - r, l, 0, 1'b0);
                    end else if (l <= fl && r > fl) begin
                        cmds[k] = mk_cmd(wfpd_pkg::DRV_LEFT, r, 2 * fl - l, 0, 1'b0);
                    end else begin
                        cmds[k] = mk_cmd(wfpd_pkg::DRV_FWD, r - FWD_OFFSET, l, 0, 1'b0);
                    end
                    k++;
                end
            end else if (right_mode) begin
                turn_right = 1'b1;
            end else begin
                turn_left = 1'b1;
            end
        end else if (turn_left) begin
            cmds[k] = mk_cmd(wfpd_pkg::DRV_LEFT, right_mode ? 0 : SPEED_SLOW, SPEED_MID, 0,
                             1'b0);
            k++;
            if (done) turn_left = 1'b0;
        end else begin
            cmds[k] = mk_cmd(wfpd_pkg::DRV_RIGHT, SPEED_MAX, right_mode ? SPEED_SLOW : 0, 0,
                             1'b0);
            k++;
            if (done) turn_right = 1'b0;
        end

        if (fr < FRONT_BACKUP_US) begin
            cmds[k] = mk_cmd(wfpd_pkg::DRV_BACK, SPEED_MAX, SPEED_MID, HOLD_BACKUP_MS, 1'b0);
            k++;
            if (right_mode) begin
                cmds[k] = mk_cmd(wfpd_pkg::DRV_LEFT, 0, SPEED_MID, HOLD_PIVOT_MS, 1'b0);
            end else begin
                cmds[k] = mk_cmd(wfpd_pkg::DRV_RIGHT, SPEED_MAX, 0, HOLD_BACKUP_MS, 1'b0);
            end
            k++;
        end

        if (k > 0) cmds[k-1].last = 1'b1;
        if (keep) begin
            for (i = 0; i < k; i++) pending_cmds.push_back(cmds[i]);
        end
    endfunction

    function automatic wfpd_pkg::in_t rand_item(int tgt);
        wfpd_pkg::in_t it;
        int  f, s, jit;
        jit = $urandom_range(0, 400);
        case ($urandom_range(0, 9))
            0, 1, 2: s = $urandom_range(0, 999);
            3:       s = $urandom_range(0, 500);
            4:       s = $urandom_range(1000, 3000);
            5:       s = $urandom_range(0, 65535);
            6: begin
                case ($urandom_range(0, 4))
                    0:       s = 499;
                    1:       s = 500;
                    2:       s = 501;
                    3:       s = 999;
                    default: s = 1000;
                endcase
            end
            7, 8: begin
                s = tgt + jit - 200;
                if (s < 0) s = 0;
                if (s > 65535) s = 65535;
            end
            default: s = $urandom_range(1000, 65535);
        endcase
        case ($urandom_range(0, 19))
            0, 1: f = $urandom_range(0, 339);
            2, 3: f = $urandom_range(340, 499);
            4:    f = $urandom_range(0, 65535);
            5: begin
                case ($urandom_range(0, 3))
                    0:       f = 339;
                    1:       f = 340;
                    2:       f = 499;
                    default: f = 500;
                endcase
            end
            default: f = $urandom_range(500, 4000);
        endcase
        it.front_echo = f[15:0];
        it.side_echo  = s[15:0];
        return it;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < PRINT_CAP) $display("ERROR %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Holds the sample valid until the transaction completes.
    task automatic send_item(wfpd_pkg::in_t it, bit keep);
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_drive_cmds(it, keep);
    endtask

    task automatic item_gap();
        if (quiet_all) return;
        if (tx_calm > 0) begin
            tx_calm--;
        end else if ($urandom_range(0, 15) == 0) begin
            tx_calm = $urandom_range(10, 40);
        end else if ($urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    // Zero-command samples may still be in flight once the queue is empty,
    // so a fixed drain follows before any register is touched.
    task automatic settle_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_cmds.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        case (idx)
            wfpd_pkg::CFG_FOLLOW_SIDE:     reg_shadow.follow_side     = val[0];
            wfpd_pkg::CFG_DISTANCE_TARGET: reg_shadow.distance_target = val;
            wfpd_pkg::CFG_BASE_SPEED:      reg_shadow.base_speed      = val[7:0];
            wfpd_pkg::CFG_SPEED_CEILING:   reg_shadow.speed_ceiling   = val[7:0];
            wfpd_pkg::CFG_SPEED_FLOOR:     reg_shadow.speed_floor     = val[7:0];
            wfpd_pkg::CFG_GAIN_PROP:       reg_shadow.gain_prop       = val[9:0];
            wfpd_pkg::CFG_GAIN_DERIV:      reg_shadow.gain_deriv      = val[9:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Result side: random stalls, quiet stretches, none in the last phase.
    always @(posedge aclk) begin
        logic rdy;
        rdy = 1'b1;
        if (!quiet_all) begin
            if (rx_stall > 0) begin
                rx_stall--;
                rdy = 1'b0;
            end else if (rx_calm > 0) begin
                rx_calm--;
            end else begin
                case ($urandom_range(0, 9))
                    0: rx_calm = $urandom_range(20, 60);
                    1, 2: begin
                        rx_stall = $urandom_range(1, 7) - 1;
                        rdy = 1'b0;
                    end
                    default: ;
                endcase
            end
        end
        m_ready <= rdy;
    end

    always @(posedge aclk) begin
        wfpd_pkg::out_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_cmds.size() == 0) begin
                report_mismatch($sformatf("unexpected command %h", m_data));
            end else begin
                want = pending_cmds.pop_front();
                if (m_data.drive !== want.drive)
                    report_mismatch($sformatf("drive got %0d want %0d",
                                              m_data.drive, want.drive));
                if (m_data.speed_a !== want.speed_a)
                    report_mismatch($sformatf("speed_a got %0d want %0d",
                                              m_data.speed_a, want.speed_a));
                if (m_data.speed_b !== want.speed_b)
                    report_mismatch($sformatf("speed_b got %0d want %0d",
                                              m_data.speed_b, want.speed_b));
                if (m_data.hold_ms !== want.hold_ms)
                    report_mismatch($sformatf("hold_ms got %0d want %0d",
                                              m_data.hold_ms, want.hold_ms));
                if (m_data.last !== want.last)
                    report_mismatch($sformatf("last got %0b want %0b",
                                              m_data.last, want.last));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("wall_follow_pd_drive_tb: FAIL");
            $finish;
        end
    end

    initial begin
        int             i, j, ph;
        wfpd_pkg::cfg_t nxt;
        wfpd_pkg::out_t nc;
        wfpd_pkg::out_t fwd0, bk, rt_bk, lt_bk, rt0, lt0, lt_r0, rt_r0;

        nc    = '0;
        fwd0  = mk_cmd(wfpd_pkg::DRV_FWD, 235 - FWD_OFFSET, 235, 0, 1'b1);
        bk    = mk_cmd(wfpd_pkg::DRV_BACK, SPEED_MAX, SPEED_MID, HOLD_BACKUP_MS, 1'b0);
        rt_bk = mk_cmd(wfpd_pkg::DRV_RIGHT, SPEED_MAX, 0, HOLD_BACKUP_MS, 1'b1);
        lt_bk = mk_cmd(wfpd_pkg::DRV_LEFT, 0, SPEED_MID, HOLD_PIVOT_MS, 1'b1);
        rt0   = mk_cmd(wfpd_pkg::DRV_RIGHT, SPEED_MAX, 0, 0, 1'b1);
        lt0   = mk_cmd(wfpd_pkg::DRV_LEFT, SPEED_SLOW, SPEED_MID, 0, 1'b1);
        lt_r0 = mk_cmd(wfpd_pkg::DRV_LEFT, 0, SPEED_MID, 0, 1'b1);
        rt_r0 = mk_cmd(wfpd_pkg::DRV_RIGHT, SPEED_MAX, SPEED_SLOW, 0, 1'b1);

        // Rows with a count of zero are checked against the model only.
        dir_tab[0]  = row_item(1000, 25, 1, fwd0, nc, nc);
        dir_tab[1]  = row_item(65535, 999, 0, nc, nc, nc);
        dir_tab[2]  = row_item(65535, 0, 0, nc, nc, nc);
        dir_tab[3]  = row_item(65535, 1000, 0, nc, nc, nc);
        dir_tab[4]  = row_item(65535, 501, 1, lt0, nc, nc);
        dir_tab[5]  = row_item(65535, 500, 1, lt0, nc, nc);
        dir_tab[6]  = row_item(499, 999, 0, nc, nc, nc);
        dir_tab[7]  = row_item(340, 65535, 1, rt0, nc, nc);
        dir_tab[8]  = row_item(339, 0, 3, mk_cmd(wfpd_pkg::DRV_RIGHT, SPEED_MAX, 0, 0, 1'b0),
                               bk, rt_bk);
        dir_tab[9]  = row_item(0, 65535, 2, bk, rt_bk, nc);
        dir_tab[10] = row_item(0, 0, 3,
                               mk_cmd(wfpd_pkg::DRV_LEFT, SPEED_SLOW, SPEED_MID, 0, 1'b0),
                               bk, rt_bk);
        dir_tab[11] = row_item(0, 999, 2, bk, rt_bk, nc);
        dir_tab[12] = row_item(65535, 65535, 1, rt0, nc, nc);
        dir_tab[13] = row_item(65535, 0, 1, rt0, nc, nc);
        dir_tab[14] = row_item(500, 25, 0, nc, nc, nc);
        dir_tab[15] = row_item(500, 998, 0, nc, nc, nc);
        dir_tab[16] = row_item(65535, 1000, 0, nc, nc, nc);
        // A left turn left over from left mode, finished in right mode.
        dir_tab[17] = row_reg(wfpd_pkg::CFG_FOLLOW_SIDE, 16'd1);
        dir_tab[18] = row_item(65535, 501, 1, lt_r0, nc, nc);
        dir_tab[19] = row_item(0, 500, 3, mk_cmd(wfpd_pkg::DRV_LEFT, 0, SPEED_MID, 0, 1'b0),
                               bk, lt_bk);
        dir_tab[20] = row_item(65535, 1000, 0, nc, nc, nc);
        dir_tab[21] = row_item(65535, 600, 1, rt_r0, nc, nc);
        dir_tab[22] = row_item(100, 400, 3,
                               mk_cmd(wfpd_pkg::DRV_RIGHT, SPEED_MAX, SPEED_SLOW, 0, 1'b0),
                               bk, lt_bk);
        dir_tab[23] = row_item(600, 700, 0, nc, nc, nc);
        // A write to an unused index must leave every register alone.
        dir_tab[24] = row_reg(REG_UNUSED, 16'hFFFF);
        dir_tab[25] = row_item(800, 30, 0, nc, nc, nc);
        dir_tab[26] = row_reg(wfpd_pkg::CFG_FOLLOW_SIDE, 16'd0);

        turn_left  = 1'b0;
        turn_right = 1'b0;
        prev_err   = 0;
        reg_shadow.follow_side     = 1'b0;
        reg_shadow.distance_target = 16'd25;
        reg_shadow.base_speed      = 8'd235;
        reg_shadow.speed_ceiling   = 8'd255;
        reg_shadow.speed_floor     = 8'd205;
        reg_shadow.gain_prop       = 10'd179;
        reg_shadow.gain_deriv      = 10'd46;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < DIR_ROWS; i++) begin
            if (dir_tab[i].is_reg) begin
                settle_idle();
                write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            end else begin
                item_gap();
                send_item(dir_tab[i].item, dir_tab[i].n_typed == 2'd0);
                // The table lists the commands of a sample in issue order.
                for (j = 0; j < int'(dir_tab[i].n_typed); j++)
                    pending_cmds.push_back(dir_tab[i].typed[j]);
            end
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == NUM_PHASES - 1) quiet_all = 1'b1;
            if (ph > 0) begin
                nxt.follow_side     = 1'($urandom_range(0, 1));
                nxt.distance_target = ($urandom_range(0, 3) == 0) ?
                                      16'($urandom_range(0, 65535)) :
                                      16'($urandom_range(0, 1500));
                nxt.base_speed      = 8'($urandom_range(0, 255));
                nxt.speed_ceiling   = 8'($urandom_range(0, 255));
                nxt.speed_floor     = 8'($urandom_range(0, 255));
                nxt.gain_prop       = 10'($urandom_range(0, 1023));
                nxt.gain_deriv      = 10'($urandom_range(0, 1023));
                case (ph)
                    1: nxt = '{follow_side: 1'b1, distance_target: 16'hFFFF,
                               base_speed: 8'hFF, speed_ceiling: 8'hFF,
                               speed_floor: 8'hFF, gain_prop: 10'h3FF,
                               gain_deriv: 10'h3FF};
                    2: nxt = '0;
                    3: begin
                        nxt.follow_side     = 1'b1;
                        nxt.distance_target = 16'd300;
                        nxt.base_speed      = 8'd200;
                        nxt.speed_ceiling   = 8'd230;
                        nxt.speed_floor     = 8'd120;
                    end
                    default: ;
                endcase
                settle_idle();
                write_reg(wfpd_pkg::CFG_FOLLOW_SIDE, 16'(nxt.follow_side));
                write_reg(wfpd_pkg::CFG_DISTANCE_TARGET, nxt.distance_target);
                write_reg(wfpd_pkg::CFG_BASE_SPEED, 16'(nxt.base_speed));
                write_reg(wfpd_pkg::CFG_SPEED_CEILING, 16'(nxt.speed_ceiling));
                write_reg(wfpd_pkg::CFG_SPEED_FLOOR, 16'(nxt.speed_floor));
                write_reg(wfpd_pkg::CFG_GAIN_PROP, 16'(nxt.gain_prop));
                write_reg(wfpd_pkg::CFG_GAIN_DERIV, 16'(nxt.gain_deriv));
            end
            for (j = 0; j < ITEMS_PER_PHASE; j++) begin
                item_gap();
                if (j == ITEMS_PER_PHASE / 2) begin
                    // Let the output side run dry before continuing.
                    s_valid <= 1'b0;
                    do @(posedge aclk); while (pending_cmds.size() != 0);
                end
                send_item(rand_item(int'(reg_shadow.distance_target)), 1'b1);
            end
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_cmds.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("wall_follow_pd_drive_tb: PASS");
        end else begin
            $display("wall_follow_pd_drive_tb: FAIL");
        end
        $finish;
    end

endmodule
